[sv/ucla_pkg.sv]
// ----------------------------------------------------------------------------
// ucla_pkg
// Shared types and constants of the UART command line assembler.
// ----------------------------------------------------------------------------
package ucla_pkg;

  localparam int unsigned LINE_CAPACITY = 192;
  localparam int unsigned STORE_DEPTH   = 2 * LINE_CAPACITY;
  localparam int unsigned STORE_AW      = $clog2(STORE_DEPTH);

  localparam int unsigned CMD_COUNT = 14;
  localparam logic [3:0]  CMD_NONE  = 4'd14;
  localparam logic [7:0]  NO_ZERO   = 8'd255;

  localparam logic [1:0] FUNC_RX      = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] END_NONE    = 2'd0;
  localparam logic [1:0] END_NEWLINE = 2'd1;
  localparam logic [1:0] END_COMMAND = 2'd2;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic        line_ready;
    logic [7:0]  line_length;
    logic [3:0]  command_id;
    logic [1:0]  line_end_kind;
    logic [7:0]  read_data;
    logic [31:0] rx_byte_count;
    logic [31:0] rx_line_count;
    logic [31:0] nonprint_count;
    logic [7:0]  current_length;
    logic [7:0]  last_received;
  } result_t;

  function automatic logic [3:0] cmd_size(input logic [3:0] k);
    logic [3:0] s;
    case (k)
      4'd0:    s = 4'd7;
      4'd1:    s = 4'd7;
      4'd2:    s = 4'd11;
      4'd3:    s = 4'd8;
      4'd4:    s = 4'd13;
      4'd5:    s = 4'd12;
      4'd6:    s = 4'd11;
      4'd7:    s = 4'd11;
      4'd8:    s = 4'd8;
      4'd9:    s = 4'd8;
      4'd10:   s = 4'd9;
      4'd11:   s = 4'd8;
      4'd12:   s = 4'd9;
      4'd13:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Text is right-justified: the last character sits in the low byte.
  function automatic logic [127:0] cmd_text(input logic [3:0] k);
    logic [127:0] t;
    case (k)
      4'd0:    t = 128'("PID GET");
      4'd1:    t = 128'("ATT GET");
      4'd2:    t = 128'("ATT DEFAULT");
      4'd3:    t = 128'("ATT ZERO");
      4'd4:    t = 128'("MAG CAL START");
      4'd5:    t = 128'("MAG CAL STOP");
      4'd6:    t = 128'("SDLOG ERASE");
      4'd7:    t = 128'("PID DEFAULT");
      4'd8:    t = 128'("PID SAVE");
      4'd9:    t = 128'("PID LOAD");
      4'd10:   t = 128'("PID DEBUG");
      4'd11:   t = 128'("BOOT LOG");
      4'd12:   t = 128'("MTEST OFF");
      4'd13:   t = 128'("MTEST 0 0");
      default: t = '0;
    endcase
    return t;
  endfunction

  // Character of command k at position p, zero past its end.
  function automatic logic [7:0] cmd_char(input logic [3:0] k, input logic [3:0] p);
    logic [127:0] t;
    logic [3:0]   s;
    logic [3:0]   b;
    t = cmd_text(k);
    s = cmd_size(k);
    b = s - p - 4'd1;
    return (p < s) ? t[{b, 3'b000} +: 8] : 8'd0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

endpackage

[sv/ucla_ram.sv]
// ----------------------------------------------------------------------------
// ucla_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ucla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/uart_command_line_assembler.sv]
// ----------------------------------------------------------------------------
// uart_command_line_assembler
// Assembles received bytes into lines, matches fixed commands, holds a line.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless the input stalls. Its result passes
// through the first stage registers and then the result register. The first
// stage updates the line state, the counters and the command candidate mask,
// and issues the line store access. The second stage takes the registered
// read of the line store RAM (two banks of LINE_CAPACITY bytes) into the
// result register. A result stall holds both stages, and the input stalls
// while the first stage is occupied and the result is stalled. Reads at or
// past the held line's length return zero.
module uart_command_line_assembler (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ucla_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ucla_pkg::result_t result
);

  localparam int unsigned AW = ucla_pkg::STORE_AW;
  localparam int unsigned NC = ucla_pkg::CMD_COUNT;

  // line state
  logic        held_bank;
  logic [7:0]  assembly_length;
  logic [7:0]  first_zero_position;
  logic [7:0]  held_length;
  logic        held_ready;
  logic [NC-1:0] candidate_mask;
  logic [3:0]  match_position;
  logic        past_leading_space;
  logic [31:0] byte_counter;
  logic [31:0] line_counter;
  logic [31:0] nonprint_counter;
  logic [7:0]  recent_byte;

  // first stage
  logic              s1_valid;
  ucla_pkg::result_t s1;
  logic              s1_read_hit;

  logic move;
  logic accept;
  assign move       = !result_valid || !result_stall;
  assign item_stall = s1_valid && !move;
  assign accept     = item_valid && !item_stall;

  logic        held_bank_next;
  logic [7:0]  assembly_length_next;
  logic [7:0]  first_zero_position_next;
  logic [7:0]  held_length_next;
  logic        held_ready_next;
  logic [NC-1:0] candidate_mask_next;
  logic [3:0]  match_position_next;
  logic        past_leading_space_next;
  logic [31:0] byte_counter_next;
  logic [31:0] line_counter_next;
  logic [31:0] nonprint_counter_next;
  logic [7:0]  recent_byte_next;
  logic [3:0]  cmd;
  logic [1:0]  kind;
  logic        read_hit;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  logic [7:0]  b;
  logic        newline;
  logic        blank;
  logic [7:0]  upper;
  logic [NC-1:0] mask_cmp;
  logic [NC-1:0] hit;
  logic [7:0]  stored_length;
  logic [7:0]  stored_zero;
  logic        finish;

  always_comb begin
    b       = item.data_byte;
    newline = (b == ucla_pkg::CHAR_CR) || (b == ucla_pkg::CHAR_LF);
    blank   = ucla_pkg::is_blank(b);
    upper   = ucla_pkg::to_upper(b);
    for (int k = 0; k < NC; k++) begin
      mask_cmp[k] = candidate_mask[k] &&
                    (match_position < ucla_pkg::cmd_size(4'(k))) &&
                    (ucla_pkg::cmd_char(4'(k), match_position) == upper);
      hit[k]      = mask_cmp[k] && !blank &&
                    (match_position + 4'd1 == ucla_pkg::cmd_size(4'(k)));
    end

    held_bank_next           = held_bank;
    assembly_length_next     = assembly_length;
    first_zero_position_next = first_zero_position;
    held_length_next         = held_length;
    held_ready_next          = held_ready;
    candidate_mask_next      = candidate_mask;
    match_position_next      = match_position;
    past_leading_space_next  = past_leading_space;
    byte_counter_next        = byte_counter;
    line_counter_next        = line_counter;
    nonprint_counter_next    = nonprint_counter;
    recent_byte_next         = recent_byte;
    cmd                      = ucla_pkg::CMD_NONE;
    kind                     = ucla_pkg::END_NONE;
    read_hit                 = 1'b0;
    wr_en                    = 1'b0;
    stored_length            = assembly_length + 8'd1;
    stored_zero              = first_zero_position;
    finish                   = 1'b0;

    wr_addr = held_bank ? AW'(assembly_length) : AW'(ucla_pkg::LINE_CAPACITY) +
              AW'(assembly_length);
    rd_addr = held_bank ? AW'(ucla_pkg::LINE_CAPACITY) + AW'(item.read_index) :
              AW'(item.read_index);

    unique case (item.func)
      ucla_pkg::FUNC_RX: begin
        byte_counter_next = byte_counter + 32'd1;
        recent_byte_next  = b;
        if ((b < ucla_pkg::CHAR_SPACE || b > ucla_pkg::CHAR_TILDE) && !newline &&
            b != ucla_pkg::CHAR_TAB) begin
          nonprint_counter_next = nonprint_counter + 32'd1;
        end
        if (newline) begin
          if (assembly_length != 8'd0) begin
            finish = 1'b1;
            kind   = ucla_pkg::END_NEWLINE;
          end
        end else if (assembly_length < 8'(ucla_pkg::LINE_CAPACITY - 1)) begin
          wr_en = 1'b1;
          if (b == 8'd0 && first_zero_position == ucla_pkg::NO_ZERO) begin
            stored_zero = assembly_length;
          end
          assembly_length_next     = stored_length;
          first_zero_position_next = stored_zero;
          if (past_leading_space || !blank) begin
            past_leading_space_next = 1'b1;
            candidate_mask_next     = (b == 8'd0) ? '0 : mask_cmp;
            match_position_next     = (match_position == 4'hF) ? match_position :
                                      match_position + 4'd1;
            if (b != 8'd0) begin
              for (int k = NC - 1; k >= 0; k--) begin
                if (hit[k]) begin
                  cmd = 4'(k);
                end
              end
            end
          end
          if (cmd != ucla_pkg::CMD_NONE) begin
            finish = 1'b1;
            kind   = ucla_pkg::END_COMMAND;
          end
        end else begin
          // overflow: drop the byte and the line
          assembly_length_next     = 8'd0;
          first_zero_position_next = ucla_pkg::NO_ZERO;
          candidate_mask_next      = '1;
          match_position_next      = 4'd0;
          past_leading_space_next  = 1'b0;
        end
        if (finish) begin
          held_length_next = (stored_zero != ucla_pkg::NO_ZERO) ? stored_zero :
                             (newline ? assembly_length : stored_length);
          held_ready_next          = 1'b1;
          line_counter_next        = line_counter + 32'd1;
          held_bank_next           = !held_bank;
          assembly_length_next     = 8'd0;
          first_zero_position_next = ucla_pkg::NO_ZERO;
          candidate_mask_next      = '1;
          match_position_next      = 4'd0;
          past_leading_space_next  = 1'b0;
        end
      end
      ucla_pkg::FUNC_READ: begin
        read_hit = item.read_index < held_length;
      end
      ucla_pkg::FUNC_RELEASE: begin
        held_ready_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  logic [7:0] ram_q;
  ucla_pkg::result_t s1_out;

  ucla_ram #(
    .WIDTH (8),
    .DEPTH (ucla_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (wr_addr),
    .wr_data (b),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    s1_out           = s1;
    s1_out.read_data = s1_read_hit ? ram_q : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bank           <= 1'b0;
      assembly_length     <= 8'd0;
      first_zero_position <= ucla_pkg::NO_ZERO;
      held_length         <= 8'd0;
      held_ready          <= 1'b0;
      candidate_mask      <= '1;
      match_position      <= 4'd0;
      past_leading_space  <= 1'b0;
      byte_counter        <= 32'd0;
      line_counter        <= 32'd0;
      nonprint_counter    <= 32'd0;
      recent_byte         <= 8'd0;
      s1_valid            <= 1'b0;
      result_valid        <= 1'b0;
    end else begin
      if (accept) begin
        held_bank           <= held_bank_next;
        assembly_length     <= assembly_length_next;
        first_zero_position <= first_zero_position_next;
        held_length         <= held_length_next;
        held_ready          <= held_ready_next;
        candidate_mask      <= candidate_mask_next;
        match_position      <= match_position_next;
        past_leading_space  <= past_leading_space_next;
        byte_counter        <= byte_counter_next;
        line_counter        <= line_counter_next;
        nonprint_counter    <= nonprint_counter_next;
        recent_byte         <= recent_byte_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_hit       <= read_hit;
      s1.line_ready     <= held_ready_next;
      s1.line_length    <= held_length_next;
      s1.command_id     <= cmd;
      s1.line_end_kind  <= kind;
      s1.read_data      <= 8'd0;
      s1.rx_byte_count  <= byte_counter_next;
      s1.rx_line_count  <= line_counter_next;
      s1.nonprint_count <= nonprint_counter_next;
      s1.current_length <= assembly_length_next;
      s1.last_received  <= recent_byte_next;
    end
    if (move && s1_valid) begin
      result <= s1_out;
    end
  end

endmodule
